[rtl/core/tpfr_pkg.sv]
// tpfr_pkg: shared types, codes and constants of the trail point fifo ribbon
// no dependencies; imported by tpfr_mul, tpfr_div and trail_point_fifo_ribbon
`default_nettype none

package tpfr_pkg;

    localparam int CAPACITY_DEF = 16;

    // shift-add multiplier operand width (abs difference of two q16.16 values)
    localparam int MUL_W = 33;
    // restoring divider: dividend and divisor widths
    localparam int DIV_NW = 48;
    localparam int DIV_DW = 32;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_POINTS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RIB_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_START = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_END   = 3'd5;

    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [16:0] FRAC_ONE = 17'd65536;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [31:0]        delta_time;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] left_x;
        logic signed [31:0] right_x;
        logic signed [31:0] vert_y;
        logic signed [31:0] vert_z;
        logic [16:0]        along_u;
        logic [31:0]        vert_color;
        logic               last;
    } t_out_word;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] age;
    } t_point;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_DIFF,
        S_MUL_GO,
        S_MUL_RUN,
        S_ADD_CMP,
        S_PUSH,
        S_AGE_RD,
        S_AGE_WR,
        S_EXP_RD,
        S_EXP_CHK,
        S_RIB_CHK,
        S_RIB_RD,
        S_RIB_F,
        S_DIVF_RUN,
        S_RIB_U,
        S_DIVU_RUN,
        S_RIB_LERP,
        S_RIB_EMIT
    } t_state;

endpackage

`default_nettype wire

[rtl/core/tpfr_ram.sv]
// tpfr_ram: generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module tpfr_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/core/tpfr_mul.sv]
// tpfr_mul: unsigned shift-add multiplier, one partial product per cycle
// depends on tpfr_pkg
`default_nettype none

module tpfr_mul (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [tpfr_pkg::MUL_W-1:0]   i_a,
    input  wire logic [tpfr_pkg::MUL_W-1:0]   i_b,
    output logic                              o_done,
    output logic      [2*tpfr_pkg::MUL_W-1:0] o_prod
);
    import tpfr_pkg::*;

    localparam int CNT_W = $clog2(MUL_W + 1);

    logic [2*MUL_W-1:0] r_a;
    logic [MUL_W-1:0]   r_b;
    logic [2*MUL_W-1:0] r_p;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(MUL_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= (2*MUL_W)'(i_a);
            r_b <= i_b;
            r_p <= '0;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_p <= r_p + r_a;
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;

endmodule

`default_nettype wire

[rtl/core/tpfr_div.sv]
// tpfr_div: unsigned restoring divider, one quotient bit per cycle
// depends on tpfr_pkg
`default_nettype none

module tpfr_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [tpfr_pkg::DIV_NW-1:0] i_num,
    input  wire logic [tpfr_pkg::DIV_DW-1:0] i_den,
    output logic                             o_done,
    output logic      [tpfr_pkg::DIV_NW-1:0] o_quot
);
    import tpfr_pkg::*;

    localparam int CNT_W = $clog2(DIV_NW + 1);

    logic [DIV_NW-1:0] r_q;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIV_DW:0]   trial;
    logic [DIV_DW:0]   diff;
    logic              ge;

    assign trial = {r_rem, r_q[DIV_NW-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
            r_q   <= {r_q[DIV_NW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

[rtl/core/trail_point_fifo_ribbon.sv]
// trail_point_fifo_ribbon: trail point fifo held in one ram, ribbon vertex builder
// depends on tpfr_pkg, tpfr_ram, tpfr_mul, tpfr_div
//
//  channel   dir  handshake                 payload
//  in        in   i_in_valid / o_in_ready    i_in_word  (tpfr_pkg::t_in_word)
//  out       out  o_out_valid / i_out_ready  o_out_word (tpfr_pkg::t_out_word)
//  cfg       in   i_cfg_we                   i_cfg_index, i_cfg_data
//
// one word at a time; clear and unknown actions finish in the idle state, add
//   pushes at once on an empty fifo and otherwise first runs four squarings
// tick ages every point, then drops expired points from the head, then per
//   ribbon vertex runs one or two divisions in the shared divider
// reset is synchronous active low; the point ram needs no clearing pass
// a finished vertex waits in the output register while the next one is built;
//   the sequencer stalls only when that register is still full
`default_nettype none

module trail_point_fifo_ribbon #(
    parameter int CAPACITY = tpfr_pkg::CAPACITY_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire tpfr_pkg::t_in_word             i_in_word,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output tpfr_pkg::t_out_word                 o_out_word,
    input  wire logic                           i_cfg_we,
    input  wire logic [tpfr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                    i_cfg_data
);
    import tpfr_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;
    localparam int PW = $bits(t_point);

    // ring position of the i-th oldest point; i may equal the capacity
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] head,
                                           input logic [CW-1:0] idx);
        logic [SW-1:0] s;
        s = SW'(head) + SW'(idx);
        if (s >= SW'(CAPACITY)) begin
            s = s - SW'(CAPACITY);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [32:0] abs_diff(input logic [31:0] a,
                                             input logic [31:0] b);
        logic [32:0] d;
        d = {a[31], a} - {b[31], b};
        return d[32] ? (33'd0 - d) : d;
    endfunction

    // configuration
    logic [31:0] r_min_dist;
    logic [4:0]  r_max_pts;
    logic [31:0] r_lifetime;
    logic [31:0] r_rib_width;
    logic [31:0] r_col_start;
    logic [31:0] r_col_end;

    // fifo bookkeeping and sequencer
    t_state        r_state, n_state;
    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_i;
    t_in_word      r_in;

    // distance test
    logic [MUL_W-1:0]     r_dx, r_dy, r_dz;
    logic [1:0]           r_sel;
    logic [2*MUL_W:0]     r_acc;
    logic [63:0]          r_m2;

    // vertex build
    t_point      r_pt;
    logic [16:0] r_f;
    logic [16:0] r_u;
    logic [31:0] r_color;
    logic        r_out_valid;
    t_out_word   r_out;

    logic [CW-1:0] eff_cap;
    logic          in_fire;
    logic          emit_fire;
    logic          expire;

    // ram
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_point        mem_wdata;
    logic [AW-1:0] mem_raddr;
    t_point        mem_rdata;

    // arithmetic units
    logic                 mul_start, mul_done;
    logic [MUL_W-1:0]     mul_a;
    logic [2*MUL_W-1:0]   mul_p;
    logic                 div_start, div_done;
    logic [DIV_NW-1:0]    div_num, div_quot;
    logic [DIV_DW-1:0]    div_den;

    logic [32:0] age_sum;
    logic [31:0] age_sat;
    logic [31:0] half;
    logic [31:0] lerp_col;

    always_comb begin
        if (r_max_pts == 5'd0) begin
            eff_cap = CW'(1);
        end else if (32'(r_max_pts) > 32'(CAPACITY)) begin
            eff_cap = CW'(CAPACITY);
        end else begin
            eff_cap = CW'(r_max_pts);
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign emit_fire  = (r_state == S_RIB_EMIT) && (!r_out_valid || i_out_ready);
    assign expire     = (mem_rdata.age > r_lifetime);

    assign age_sum = {1'b0, mem_rdata.age} + {1'b0, r_in.delta_time};
    assign age_sat = age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
    assign half    = r_rib_width >> 1;

    // squaring operand: dx, dy, dz, then the spacing threshold
    always_comb begin
        case (r_sel)
            2'd0:    mul_a = r_dx;
            2'd1:    mul_a = r_dy;
            2'd2:    mul_a = r_dz;
            default: mul_a = {1'b0, r_min_dist};
        endcase
    end

    // per-channel colour lerp, one small multiply per channel
    always_comb begin
        logic signed [26:0] s_ch;
        logic signed [26:0] e_ch;
        logic signed [26:0] f_w;
        logic signed [26:0] v;
        lerp_col = '0;
        for (int c = 0; c < 4; c++) begin
            s_ch = {19'd0, r_col_start[8*c +: 8]};
            e_ch = {19'd0, r_col_end[8*c +: 8]};
            f_w  = {10'd0, r_f};
            v = (s_ch <<< 16) + (e_ch - s_ch) * f_w;
            lerp_col[8*c +: 8] = v[23:16];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (i_in_word.action)
                        ACT_ADD:  n_state = S_ADD_RD;
                        ACT_TICK: n_state = S_AGE_RD;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD_RD:   n_state = (r_count == '0) ? S_PUSH : S_ADD_DIFF;
            S_ADD_DIFF: n_state = S_MUL_GO;
            S_MUL_GO:   n_state = S_MUL_RUN;
            S_MUL_RUN: begin
                if (mul_done) begin
                    n_state = (r_sel == 2'd3) ? S_ADD_CMP : S_MUL_GO;
                end
            end
            S_ADD_CMP:  n_state = (r_acc < (2*MUL_W+1)'(r_m2)) ? S_IDLE : S_PUSH;
            S_PUSH:     n_state = S_IDLE;
            S_AGE_RD:   n_state = (r_i == r_count) ? S_EXP_RD : S_AGE_WR;
            S_AGE_WR:   n_state = S_AGE_RD;
            S_EXP_RD:   n_state = (r_count == '0) ? S_RIB_CHK : S_EXP_CHK;
            S_EXP_CHK:  n_state = expire ? S_EXP_RD : S_RIB_CHK;
            S_RIB_CHK:  n_state = (r_count < CW'(2)) ? S_IDLE : S_RIB_RD;
            S_RIB_RD:   n_state = S_RIB_F;
            S_RIB_F:    n_state = (r_lifetime == '0) ? S_RIB_U : S_DIVF_RUN;
            S_DIVF_RUN: n_state = div_done ? S_RIB_U : S_DIVF_RUN;
            S_RIB_U:    n_state = S_DIVU_RUN;
            S_DIVU_RUN: n_state = div_done ? S_RIB_LERP : S_DIVU_RUN;
            S_RIB_LERP: n_state = S_RIB_EMIT;
            S_RIB_EMIT: begin
                if (emit_fire) begin
                    n_state = (r_i == r_count - CW'(1)) ? S_IDLE : S_RIB_RD;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // ram and unit controls; every read and write of one entry is a separate
    // step of the sequencer, so no access overlaps a pending write
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = slot(r_head, r_i);
        mem_wdata = mem_rdata;
        mem_raddr = slot(r_head, r_i);
        mul_start = 1'b0;
        div_start = 1'b0;
        div_num   = {mem_rdata.age, 16'h0};
        div_den   = r_lifetime;
        case (r_state)
            S_ADD_RD:  mem_raddr = slot(r_head, r_count - CW'(1));
            S_MUL_GO:  mul_start = 1'b1;
            S_PUSH: begin
                mem_we    = 1'b1;
                mem_waddr = slot(r_head, r_count);
                mem_wdata = '{x: r_in.pos_x, y: r_in.pos_y, z: r_in.pos_z, age: 32'd0};
            end
            S_AGE_WR: begin
                mem_we        = 1'b1;
                mem_wdata.age = age_sat;
            end
            S_EXP_RD:  mem_raddr = r_head;
            S_RIB_F:   div_start = (r_lifetime != '0);
            S_RIB_U: begin
                div_start = 1'b1;
                div_num   = DIV_NW'(r_i) << 16;
                div_den   = DIV_DW'(r_count - CW'(1));
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_i         <= '0;
            r_sel       <= '0;
            r_out_valid <= 1'b0;
            r_min_dist  <= 32'd0;
            r_max_pts   <= 5'd16;
            r_lifetime  <= 32'd65536;
            r_rib_width <= 32'd65536;
            r_col_start <= 32'hFFFF_FFFF;
            r_col_end   <= 32'd0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MIN_DIST:    r_min_dist  <= i_cfg_data;
                    CFG_MAX_POINTS:  r_max_pts   <= i_cfg_data[4:0];
                    CFG_LIFETIME:    r_lifetime  <= i_cfg_data;
                    CFG_RIB_WIDTH:   r_rib_width <= i_cfg_data;
                    CFG_COLOR_START: r_col_start <= i_cfg_data;
                    CFG_COLOR_END:   r_col_end   <= i_cfg_data;
                    default:         r_min_dist  <= r_min_dist;
                endcase
            end

            // a new vertex refills the register, else a taken one empties it
            if (emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    r_i <= '0;
                    if (in_fire && i_in_word.action == ACT_CLEAR) begin
                        r_head  <= '0;
                        r_count <= '0;
                    end
                end
                S_ADD_DIFF: r_sel <= '0;
                S_MUL_RUN: begin
                    if (mul_done) begin
                        r_sel <= r_sel + 2'd1;
                    end
                end
                S_PUSH: begin
                    // a full fifo drops its oldest point; the count stays
                    if (r_count >= eff_cap) begin
                        r_head <= slot(r_head, CW'(1));
                    end else begin
                        r_count <= r_count + CW'(1);
                    end
                end
                S_AGE_WR: r_i <= r_i + CW'(1);
                S_EXP_CHK: begin
                    if (expire) begin
                        r_head  <= slot(r_head, CW'(1));
                        r_count <= r_count - CW'(1);
                    end
                end
                S_RIB_CHK: r_i <= '0;
                S_RIB_EMIT: begin
                    if (emit_fire) begin
                        r_i <= r_i + CW'(1);
                    end
                end
                default: begin
                    r_i <= r_i;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= i_in_word;
        end
        if (r_state == S_ADD_DIFF) begin
            r_dx  <= abs_diff(r_in.pos_x, mem_rdata.x);
            r_dy  <= abs_diff(r_in.pos_y, mem_rdata.y);
            r_dz  <= abs_diff(r_in.pos_z, mem_rdata.z);
            r_acc <= '0;
        end
        if (r_state == S_MUL_RUN && mul_done) begin
            if (r_sel == 2'd3) begin
                r_m2 <= mul_p[63:0];
            end else begin
                r_acc <= r_acc + (2*MUL_W+1)'(mul_p);
            end
        end
        if (r_state == S_RIB_F) begin
            r_pt <= mem_rdata;
            if (r_lifetime == '0) begin
                r_f <= '0;
            end
        end
        if (r_state == S_DIVF_RUN && div_done) begin
            r_f <= (div_quot > DIV_NW'(FRAC_ONE)) ? FRAC_ONE : div_quot[16:0];
        end
        if (r_state == S_DIVU_RUN && div_done) begin
            r_u <= div_quot[16:0];
        end
        if (r_state == S_RIB_LERP) begin
            r_color <= lerp_col;
        end
        if (emit_fire) begin
            r_out.left_x     <= r_pt.x - half;
            r_out.right_x    <= r_pt.x + half;
            r_out.vert_y     <= r_pt.y;
            r_out.vert_z     <= r_pt.z;
            r_out.along_u    <= r_u;
            r_out.vert_color <= r_color;
            r_out.last       <= (r_i == r_count - CW'(1));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    tpfr_ram #(
        .WIDTH (PW),
        .DEPTH (CAPACITY)
    ) u_point_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    tpfr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_a),
        .o_done  (mul_done),
        .o_prod  (mul_p)
    );

    tpfr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // fifo never holds more than the ram depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("point count above capacity");

    // a clear empties the fifo
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_word.action == ACT_CLEAR) |=> (r_count == '0))
        else $error("clear left points behind");

    // vertices only come out of a run of at least two points
    a_emit_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_fire |-> (r_count >= CW'(2)))
        else $error("vertex from fewer than two points");

    // a push into a full fifo keeps the count
    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH && r_count >= eff_cap) |=> (r_count == $past(r_count)))
        else $error("full push changed count");

endmodule

`default_nettype wire
